// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sg_pkg.sv =====
package sg_pkg;

  // Width of the divider and of its operands
  localparam int unsigned DW = 48;

  // Item mode codes
  localparam logic [2:0] MODE_MOVE    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_RELEASE = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_FULL_STEPS = 3'd0;
  localparam logic [2:0] CFG_MICROSTEP  = 3'd1;
  localparam logic [2:0] CFG_GEAR       = 3'd2;
  localparam logic [2:0] CFG_UPPER      = 3'd3;
  localparam logic [2:0] CFG_LOWER      = 3'd4;

  // Configuration reset values
  localparam logic [9:0]         RST_FULL_STEPS = 10'd200;
  localparam logic [8:0]         RST_MICROSTEP  = 9'd16;
  localparam logic [15:0]        RST_GEAR       = 16'd256;
  localparam logic signed [15:0] RST_UPPER      = 16'sd800;
  localparam logic signed [15:0] RST_LOWER      = -16'sd800;
  localparam logic [15:0]        RST_TARGET     = 16'd85;

  // Arithmetic constants
  localparam longint unsigned SECONDS_PER_MIN = 60;
  localparam longint unsigned Q8_ONE          = 256;
  localparam longint unsigned DEG_PER_REV     = 360;
  localparam int unsigned     HALF_STEP_SHIFT = 4;  // 2 * 8 = 16 ticks per unit

  // Target scaling by 256 * 360: shift out 256 * 8, then divide by 45
  // through a reciprocal multiply that is exact below the saturation point
  localparam int unsigned TG_PRE_SHIFT   = 11;
  localparam logic [31:0] TG_SAT_LIMIT   = 32'(45 * 32768);
  localparam logic [21:0] TG_RECIP       = 22'd2982617;  // ceil(2^27 / 45)
  localparam int unsigned TG_RECIP_SHIFT = 27;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec_item;    // apply a start, stop, release or tick word
    logic latch_move;   // capture the move operands
    logic mul_a;        // steps * microstep
    logic mul_b;        // * gear ratio
    logic mul_c;        // denominator and target product
    logic div_start;    // launch the half-period divider
    logic calc_tgt;     // scale the target product down to steps
    logic store_hp;     // write the half-period from the quotient
    logic commit_move;  // write target and direction
  } sg_cmd_t;

endpackage

// ===== design/sg_div.sv =====
module sg_div
  import sg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW:0]   rem_shift;
  logic [DW+1:0] diff;
  logic          borrow;

  // One restoring step: shift in the next dividend bit, try a subtract
  assign rem_shift = {rem, quo[DW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
  assign borrow    = diff[DW+1];
  assign quotient  = quo;

  // Control: run DW steps after start, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Data: load operands, then shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= borrow ? rem_shift[DW-1:0] : diff[DW-1:0];
      quo <= {quo[DW-2:0], ~borrow};
    end
  end

endmodule

// ===== design/sg_dp.sv =====
module sg_dp
  import sg_pkg::*;
#(
  parameter int unsigned CLOCK_HZ = 32000000
) (
  input  logic               clk,
  input  logic               rst,
  input  sg_cmd_t            cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         mode,
  input  logic [7:0]         speed_rpm,
  input  logic signed [7:0]  angle_deg,
  input  logic               move_direction,
  output logic               div_done,
  output logic               step_level,
  output logic               direction_level,
  output logic               enable_level,
  output logic               running,
  output logic signed [15:0] position,
  output logic               stopped_now
);

  localparam logic [DW-1:0] HP_NUM =
    DW'(64'(CLOCK_HZ) * SECONDS_PER_MIN * Q8_ONE);

  // Configuration registers
  logic [9:0]         full_steps;
  logic [8:0]         microstep_ratio;
  logic [15:0]        gear_ratio_q8;
  logic signed [15:0] upper_limit;
  logic signed [15:0] lower_limit;

  // Axis state
  logic [15:0] position_count;
  logic [15:0] target_count;
  logic        dir_flag;
  logic        run_flag;
  logic        enable_flag;
  logic [15:0] half_period;
  logic [15:0] tick_count;
  logic        pin_level;
  logic        stopped;

  // Move operands and products
  logic [7:0]    speed_q;
  logic [7:0]    mag_q;
  logic          neg_q;
  logic          dir_q;
  logic [18:0]   p_steps;
  logic [34:0]   ppr;
  logic [DW-1:0] den;
  logic [42:0]   prod;

  // Divider link
  logic [DW-1:0] quo;

  // Tick evaluation
  logic [15:0] pos_step;
  logic        tick_match;
  logic        hit;
  logic        tick_stop;

  // Saturation of the half-period and target scaling
  logic [15:0] hp_value;
  logic [31:0] tg_scaled;
  logic [42:0] tg_recip;
  logic [16:0] tg_mag;
  logic [16:0] tgt_mag;
  logic [15:0] tgt_value;
  logic [7:0]  mag_in;

  assign mag_in = angle_deg[7] ? (8'd128 - {1'b0, angle_deg[6:0]}) : {1'b0, angle_deg[6:0]};

  assign pos_step   = dir_flag ? (position_count + 16'd1) : (position_count - 16'd1);
  assign tick_match = (tick_count >= half_period);
  assign hit        = (pos_step == target_count) || ($signed(pos_step) >= upper_limit) ||
                      ($signed(pos_step) <= lower_limit);
  assign tick_stop  = (mode == MODE_TICK) && run_flag && tick_match && hit;

  // Half-period: zero denominator holds the slowest rate, zero quotient clamps to 0, a quotient above 65536 saturates
  always_comb begin
    if (den == '0) begin
      hp_value = 16'hFFFF;
    end else if (quo == '0) begin
      hp_value = 16'd0;
    end else if (quo > DW'(65536)) begin
      hp_value = 16'hFFFF;
    end else begin
      hp_value = 16'(quo - DW'(1));
    end
  end

  // Target magnitude: drop 256 * 8, multiply by 1/45, clamp at 32768
  assign tg_scaled = prod[42:TG_PRE_SHIFT];
  assign tg_recip  = tg_scaled[20:0] * TG_RECIP;
  assign tg_mag    = (tg_scaled >= TG_SAT_LIMIT) ? 17'd32768 :
                     {1'b0, tg_recip[TG_RECIP_SHIFT +: 16]};

  // Target: apply the sign to the clamped magnitude
  always_comb begin
    if (neg_q) begin
      tgt_value = 16'(17'd0 - tgt_mag);
    end else if (tgt_mag > 17'd32767) begin
      tgt_value = 16'h7FFF;
    end else begin
      tgt_value = tgt_mag[15:0];
    end
  end

  sg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (HP_NUM),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      full_steps      <= RST_FULL_STEPS;
      microstep_ratio <= RST_MICROSTEP;
      gear_ratio_q8   <= RST_GEAR;
      upper_limit     <= RST_UPPER;
      lower_limit     <= RST_LOWER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_STEPS: full_steps      <= cfg_data[9:0];
        CFG_MICROSTEP:  microstep_ratio <= cfg_data[8:0];
        CFG_GEAR:       gear_ratio_q8   <= cfg_data;
        CFG_UPPER:      upper_limit     <= $signed(cfg_data);
        CFG_LOWER:      lower_limit     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Move pipeline: latch operands, then one multiply step per cycle
  always_ff @(posedge clk) begin
    if (cmd.latch_move) begin
      speed_q <= speed_rpm;
      mag_q   <= mag_in;
      neg_q   <= angle_deg[7];
      dir_q   <= move_direction;
    end
    if (cmd.mul_a) begin
      p_steps <= full_steps * microstep_ratio;
    end
    if (cmd.mul_b) begin
      ppr <= p_steps * gear_ratio_q8;
    end
    if (cmd.mul_c) begin
      den  <= DW'({8'd0, ppr} * {35'd0, speed_q}) << HALF_STEP_SHIFT;
      prod <= ppr * mag_q;
    end
    if (cmd.calc_tgt) begin
      tgt_mag <= tg_mag;
    end
  end

  // Axis state update
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      target_count   <= RST_TARGET;
      dir_flag       <= 1'b0;
      run_flag       <= 1'b0;
      enable_flag    <= 1'b0;
      half_period    <= '0;
      tick_count     <= '0;
      pin_level      <= 1'b0;
      stopped        <= 1'b0;
    end else begin
      if (cmd.exec_item) begin
        stopped <= tick_stop;
        case (mode)
          MODE_START: begin
            run_flag    <= 1'b1;
            enable_flag <= 1'b1;
          end
          MODE_STOP: begin
            run_flag <= 1'b0;
          end
          MODE_RELEASE: begin
            enable_flag <= 1'b0;
          end
          MODE_TICK: begin
            if (run_flag) begin
              if (tick_match) begin
                tick_count     <= '0;
                pin_level      <= ~pin_level;
                position_count <= pos_step;
                if (hit) begin
                  run_flag <= 1'b0;
                end
              end else begin
                tick_count <= tick_count + 16'd1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.store_hp) begin
        half_period <= hp_value;
      end
      if (cmd.commit_move) begin
        target_count <= tgt_value;
        dir_flag     <= dir_q;
        stopped      <= 1'b0;
      end
    end
  end

  assign step_level      = pin_level;
  assign direction_level = dir_flag;
  assign enable_level    = enable_flag;
  assign running         = run_flag;
  assign position        = $signed(position_count);
  assign stopped_now     = stopped;

endmodule

// ===== design/sg_ctrl.sv =====
module sg_ctrl
  import sg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] mode,
  input  logic       out_stall,
  input  logic       div_done,
  output logic       in_stall,
  output logic       out_valid,
  output sg_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MUL_A   = 6'b000010,
    S_MUL_B   = 6'b000100,
    S_MUL_C   = 6'b001000,
    S_HP_GO   = 6'b010000,
    S_HP_WAIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_set;

  // Take a word only when idle and the result register is free
  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Apply other words on accept; sequence a move through the multipliers, target scaling and one division
  always_comb begin
    state_next = state;
    cmd        = '0;
    out_set    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_MOVE) begin
            cmd.latch_move = 1'b1;
            state_next     = S_MUL_A;
          end else begin
            cmd.exec_item = 1'b1;
            out_set       = 1'b1;
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_c  = 1'b1;
        state_next = S_HP_GO;
      end
      S_HP_GO: begin
        cmd.div_start = 1'b1;
        cmd.calc_tgt  = 1'b1;
        state_next    = S_HP_WAIT;
      end
      S_HP_WAIT: begin
        if (div_done) begin
          cmd.store_hp    = 1'b1;
          cmd.commit_move = 1'b1;
          out_set         = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/stepper_axis_step_generator_unit.sv =====
// Start, stop, release, tick and unused modes: result word valid in the cycle after accept.
// Move: states MUL_A, MUL_B and MUL_C multiply, HP_GO scales the target and starts the divider,
// then a 48-step divider pass, and HP_WAIT stores the result on done.
// One word in flight at a time; the next is taken as the result word is taken.
// Synchronous active-high reset: axis stopped, position 0, target 85,
// configuration back to 200 steps, 16 microsteps, gear 1.0, limits +/-800.
module stepper_axis_step_generator_unit
  import sg_pkg::*;
#(
  parameter int unsigned CLOCK_HZ = 32000000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [7:0]         speed_rpm,
  input  logic signed [7:0]  angle_deg,
  input  logic               move_direction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               step_level,
  output logic               direction_level,
  output logic               enable_level,
  output logic               running,
  output logic signed [15:0] position,
  output logic               stopped_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sg_cmd_t cmd;
  logic    div_done;
  logic    cfg_we;

  // Configuration is always taken outside reset
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  sg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .out_stall (out_stall),
    .div_done  (div_done),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sg_dp #(
    .CLOCK_HZ (CLOCK_HZ)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .speed_rpm       (speed_rpm),
    .angle_deg       (angle_deg),
    .move_direction  (move_direction),
    .div_done        (div_done),
    .step_level      (step_level),
    .direction_level (direction_level),
    .enable_level    (enable_level),
    .running         (running),
    .position        (position),
    .stopped_now     (stopped_now)
  );

endmodule

// ===== design/sg_checker.sv =====
`include "assert_macros.svh"

module sg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         mode,
  input logic [7:0]         speed_rpm,
  input logic signed [7:0]  angle_deg,
  input logic               move_direction,
  input logic               out_valid,
  input logic               out_stall,
  input logic               step_level,
  input logic               direction_level,
  input logic               enable_level,
  input logic               running,
  input logic signed [15:0] position,
  input logic               stopped_now,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  // Reset empties the result register and halts the axis
  `SG_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (!out_valid && !running), "reset left a result or motion")

  // An axis that just stopped is reported as not running
  `SG_ASSERT(a_stop_not_running, clk, rst, (out_valid && stopped_now) |-> !running, "stopped_now while running")

  // No new word enters while a result waits
  `SG_ASSERT(a_block_on_pending, clk, rst, (out_valid && out_stall) |-> in_stall, "word taken with result pending")

  // A waiting result keeps its position
  `SG_ASSERT(a_hold_result, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(position)), "stalled result changed")

endmodule

bind stepper_axis_step_generator_unit sg_checker u_sg_checker (.*);
